/* src/dbpc_pkg.sv */
// ----------------------------------------------------------------------------
// dbpc_pkg
// shared types and constants of the dual button press classifier
// ----------------------------------------------------------------------------
package dbpc_pkg;

  localparam int TIME_W  = 32;  // millisecond timestamp width
  localparam int CFG_W   = 16;  // configuration register width
  localparam int CFG_IDX_W = 2; // configuration index width
  localparam int EV_W    = 3;   // event code width
  localparam int QLVL_W  = 3;   // reported queue level width
  localparam int NUM_BTN = 2;

  // ring queue of events, one slot always kept free
  localparam int RING_DEPTH = 8;
  localparam int RING_PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RING_LVL_W = RING_PTR_W + 1;

  // decoupling queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = CFG_IDX_W'(1);

  // event codes
  localparam logic [EV_W-1:0] EV_NONE         = EV_W'(0);
  localparam logic [EV_W-1:0] EV_FIRST_SHORT  = EV_W'(1);
  localparam logic [EV_W-1:0] EV_FIRST_LONG   = EV_W'(2);
  localparam logic [EV_W-1:0] EV_SECOND_SHORT = EV_W'(3);
  localparam logic [EV_W-1:0] EV_SECOND_LONG  = EV_W'(4);

  typedef logic [EV_W-1:0]   ev_code_t;
  typedef logic [TIME_W-1:0] ms_time_t;
  typedef logic [CFG_W-1:0]  cfg_val_t;

  // one classified poll: the event of each button and the pop request
  typedef struct packed {
    ev_code_t ev_first;
    ev_code_t ev_second;
    logic     pop;
  } dbpc_item_t;

  // configuration seen by the front
  typedef struct packed {
    cfg_val_t debounce;
    cfg_val_t long_press;
  } dbpc_cfg_t;

endpackage

/* src/dbpc_front.sv */
// ----------------------------------------------------------------------------
// dbpc_front
// debounces both buttons and classifies short and long presses per poll
// ----------------------------------------------------------------------------
module dbpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  dbpc_pkg::dbpc_cfg_t cfg,
  input  dbpc_pkg::ms_time_t  now_ms,
  input  logic [1:0]          pressed_raw,
  input  logic                pop_request,
  output dbpc_pkg::dbpc_item_t item
);
  import dbpc_pkg::*;

  logic [NUM_BTN-1:0] raw_r, raw_nxt;
  logic [NUM_BTN-1:0] stable_r, stable_nxt;
  logic [NUM_BTN-1:0] long_sent_r, long_sent_nxt;
  ms_time_t           edge_r [NUM_BTN];
  ms_time_t           edge_nxt [NUM_BTN];
  ms_time_t           press_r [NUM_BTN];
  ms_time_t           press_nxt [NUM_BTN];
  ev_code_t           ev [NUM_BTN];

  always_comb begin
    for (int b = 0; b < NUM_BTN; b++) begin
      logic     raw_chg;
      logic     deb_ok;
      logic     stab_chg;
      logic     to_press;
      logic     to_release;
      logic     short_hit;
      logic     long_mid;
      logic     long_hit;
      ms_time_t db_diff;
      ms_time_t lp_diff;

      raw_chg     = pressed_raw[b] != raw_r[b];
      raw_nxt[b]  = pressed_raw[b];
      edge_nxt[b] = raw_chg ? now_ms : edge_r[b];

      // a fresh edge has zero elapsed time
      db_diff  = now_ms - edge_r[b];
      deb_ok   = raw_chg ? (cfg.debounce == '0)
                         : (db_diff >= TIME_W'(cfg.debounce));
      stab_chg = deb_ok && (stable_r[b] != pressed_raw[b]);

      to_press   = stab_chg && pressed_raw[b];
      to_release = stab_chg && !pressed_raw[b];
      short_hit  = to_release && !long_sent_r[b];

      stable_nxt[b] = stab_chg ? pressed_raw[b] : stable_r[b];
      press_nxt[b]  = to_press ? now_ms : press_r[b];
      long_mid      = to_press ? 1'b0 : long_sent_r[b];

      // press that just became stable has zero held time
      lp_diff  = now_ms - press_r[b];
      long_hit = stable_nxt[b] && !long_mid &&
                 (to_press ? (cfg.long_press == '0)
                           : (lp_diff >= TIME_W'(cfg.long_press)));
      long_sent_nxt[b] = long_mid | long_hit;

      if (short_hit) begin
        ev[b] = (b == 0) ? EV_FIRST_SHORT : EV_SECOND_SHORT;
      end else if (long_hit) begin
        ev[b] = (b == 0) ? EV_FIRST_LONG : EV_SECOND_LONG;
      end else begin
        ev[b] = EV_NONE;
      end
    end
  end

  assign item.ev_first  = ev[0];
  assign item.ev_second = ev[1];
  assign item.pop       = pop_request;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r       <= '0;
      stable_r    <= '0;
      long_sent_r <= '0;
      for (int b = 0; b < NUM_BTN; b++) begin
        edge_r[b]  <= '0;
        press_r[b] <= '0;
      end
    end else if (accept) begin
      raw_r       <= raw_nxt;
      stable_r    <= stable_nxt;
      long_sent_r <= long_sent_nxt;
      for (int b = 0; b < NUM_BTN; b++) begin
        edge_r[b]  <= edge_nxt[b];
        press_r[b] <= press_nxt[b];
      end
    end
  end

endmodule

/* src/dbpc_fifo.sv */
// ----------------------------------------------------------------------------
// dbpc_fifo
// short queue of classified polls between front and back
// ----------------------------------------------------------------------------
module dbpc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dbpc_pkg::dbpc_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output dbpc_pkg::dbpc_item_t pop_item
);
  import dbpc_pkg::*;

  dbpc_item_t            slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = count_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign valid    = count_r != '0;
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // no push into a full queue and no pop from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !valid |-> !pop) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

/* src/dbpc_back.sv */
// ----------------------------------------------------------------------------
// dbpc_back
// event ring queue: pushes the classified events, serves pops, registers result
// ----------------------------------------------------------------------------
module dbpc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  dbpc_pkg::dbpc_item_t item,
  output logic                 item_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dbpc_pkg::ev_code_t   out_event_code,
  output logic [dbpc_pkg::QLVL_W-1:0] out_queue_level
);
  import dbpc_pkg::*;

  typedef logic [RING_PTR_W-1:0] ring_ptr_t;

  ev_code_t          ring_r [RING_DEPTH];
  ring_ptr_t         head_r, head_nxt;
  ring_ptr_t         tail_r, tail_nxt;
  logic              out_valid_r;
  ev_code_t          out_code_r, out_code_nxt;
  logic [QLVL_W-1:0] out_level_r, out_level_nxt;

  logic              first_ok, second_ok, pop_hit;
  ring_ptr_t         tail_mid;
  logic [RING_LVL_W-1:0] level;

  function automatic ring_ptr_t ring_inc(input ring_ptr_t p);
    ring_inc = (p == RING_PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign item_take = item_valid && (!out_valid_r || out_ready);

  always_comb begin
    // first button event, then second, each dropped when the ring is full
    first_ok  = (item.ev_first != EV_NONE) && (ring_inc(tail_r) != head_r);
    tail_mid  = first_ok ? ring_inc(tail_r) : tail_r;
    second_ok = (item.ev_second != EV_NONE) && (ring_inc(tail_mid) != head_r);
    tail_nxt  = second_ok ? ring_inc(tail_mid) : tail_mid;

    pop_hit  = item.pop && (head_r != tail_nxt);
    head_nxt = pop_hit ? ring_inc(head_r) : head_r;

    // an empty ring hands back the event pushed in the same transaction
    if (!pop_hit) begin
      out_code_nxt = EV_NONE;
    end else if (head_r == tail_r) begin
      out_code_nxt = first_ok ? item.ev_first : item.ev_second;
    end else begin
      out_code_nxt = ring_r[head_r];
    end

    if (tail_nxt >= head_nxt) begin
      level = RING_LVL_W'(tail_nxt) - RING_LVL_W'(head_nxt);
    end else begin
      level = RING_LVL_W'(tail_nxt) + RING_LVL_W'(RING_DEPTH) - RING_LVL_W'(head_nxt);
    end
    out_level_nxt = QLVL_W'(level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_code_r  <= out_code_nxt;
      out_level_r <= out_level_nxt;
      if (first_ok) begin
        ring_r[tail_r] <= item.ev_first;
      end
      if (second_ok) begin
        ring_r[tail_mid] <= item.ev_second;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_code  = out_code_r;
  assign out_queue_level = out_level_r;

  a_no_pop_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && !item.pop |=> out_code_r == EV_NONE)
    else $error("event returned without pop request");
  a_head_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && !item.pop |=> head_r == $past(head_r))
    else $error("ring head moved without pop");
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_code_r == EV_NONE || out_code_r == EV_FIRST_SHORT ||
                     out_code_r == EV_FIRST_LONG || out_code_r == EV_SECOND_SHORT ||
                     out_code_r == EV_SECOND_LONG))
    else $error("invalid event code on output");

endmodule

/* src/dual_button_press_classifier.sv */
// ----------------------------------------------------------------------------
// dual_button_press_classifier
// debounces two buttons, classifies short and long presses, queues events
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  in_      input      in_valid / in_ready     now_ms, first/second_pressed_raw,
//                                              pop_request
//  out_     output     out_valid / out_ready   event_code, queue_level
//  cfg_     input      cfg_wr_en (no wait)     cfg_index, cfg_wdata
//
//  one transaction per cycle sustained while out_ready stays high; a poll
//  reaches its result through the registered path below
//  (front -> two-entry queue -> back output register)
//  the front takes a poll whenever the queue has room; the back drains it
//  whenever the output register is empty or being taken
//  synchronous active-low reset clears button state, ring pointers, queue
//  and configuration (debounce 50 ms, long press 1000 ms)
//  ring contents are not reset; only entries that were written get popped
//
module dual_button_press_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [dbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dbpc_pkg::CFG_W-1:0]        cfg_wdata,
  // poll input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dbpc_pkg::TIME_W-1:0]       in_now_ms,
  input  logic                              in_first_pressed_raw,
  input  logic                              in_second_pressed_raw,
  input  logic                              in_pop_request,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dbpc_pkg::EV_W-1:0]         out_event_code,
  output logic [dbpc_pkg::QLVL_W-1:0]       out_queue_level
);
  import dbpc_pkg::*;

  cfg_val_t   debounce_r;
  cfg_val_t   long_press_r;
  dbpc_cfg_t  cfg;

  logic       fifo_full;
  logic       in_accept;
  dbpc_item_t front_item;
  logic       fifo_valid;
  dbpc_item_t fifo_item;
  logic       back_take;

  // writes beyond the defined registers are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= CFG_W'(50);
      long_press_r <= CFG_W'(1000);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.debounce   = debounce_r;
  assign cfg.long_press = long_press_r;

  // a poll is taken as soon as the decoupling queue has room
  assign in_ready  = !fifo_full;
  assign in_accept = in_valid && in_ready;

  // front: debounce and press classification, state updated per transaction
  dbpc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .cfg         (cfg),
    .now_ms      (in_now_ms),
    .pressed_raw ({in_second_pressed_raw, in_first_pressed_raw}),
    .pop_request (in_pop_request),
    .item        (front_item)
  );

  // queue between classification and ring handling
  dbpc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_item (front_item),
    .full      (fifo_full),
    .pop       (back_take),
    .valid     (fifo_valid),
    .pop_item  (fifo_item)
  );

  // back: event ring pushes, pop, registered result
  dbpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (fifo_valid),
    .item            (fifo_item),
    .item_take       (back_take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_code  (out_event_code),
    .out_queue_level (out_queue_level)
  );

endmodule

/* verif/dual_button_press_classifier_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_button_press_classifier_tb
// drives polls of two buttons through the classifier under random flow
// control and compares every event and queue level with a local predictor
// ----------------------------------------------------------------------------
module dual_button_press_classifier_tb;
  import dbpc_pkg::*;

  localparam int CLK_HALF    = 10;      // 20 ns period
  localparam int CYCLE_LIMIT = 400000;  // far beyond the slowest legal run
  localparam int DRAIN_SLACK = 4;       // margin after the last pending result
  localparam int MAX_PRINTED = 50;      // keep a broken run readable

  // register indexes past the two real ones, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  // register values after reset
  localparam cfg_val_t DEBOUNCE_RESET   = cfg_val_t'(50);
  localparam cfg_val_t LONG_PRESS_RESET = cfg_val_t'(1000);

  typedef struct packed {
    ev_code_t              code;
    logic [QLVL_W-1:0]     level;
  } poll_result_t;

  // --------------------------------------------------------------------------
  // predictor of the button state and event ring, plus the pending results
  // --------------------------------------------------------------------------
  class press_classifier_sb;
    cfg_val_t     debounce_ms;
    cfg_val_t     long_ms;
    logic         raw_lvl    [NUM_BTN];
    logic         stable_lvl [NUM_BTN];
    logic         long_done  [NUM_BTN];
    ms_time_t     edge_at    [NUM_BTN];
    ms_time_t     press_at   [NUM_BTN];
    ev_code_t     ring       [RING_DEPTH];
    int unsigned  head;
    int unsigned  tail;
    poll_result_t pending_results [$];
    int unsigned  errors;

    function new();
      debounce_ms = DEBOUNCE_RESET;
      long_ms     = LONG_PRESS_RESET;
      for (int b = 0; b < NUM_BTN; b++) begin
        raw_lvl[b]    = 1'b0;
        stable_lvl[b] = 1'b0;
        long_done[b]  = 1'b0;
        edge_at[b]    = '0;
        press_at[b]   = '0;
      end
      head   = 0;
      tail   = 0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, cfg_val_t val);
      case (idx)
        CFG_DEBOUNCE:   debounce_ms = val;
        CFG_LONG_PRESS: long_ms     = val;
        default: ;
      endcase
    endfunction

    // one slot stays free, an event that finds the ring full is lost
    function void push_event(ev_code_t code);
      int unsigned nxt;
      nxt = (tail + 1) % RING_DEPTH;
      if (nxt == head) return;
      ring[tail] = code;
      tail = nxt;
    endfunction

    function ev_code_t pop_event();
      ev_code_t code;
      if (head == tail) return EV_NONE;
      code = ring[head];
      head = (head + 1) % RING_DEPTH;
      return code;
    endfunction

    function void debounce_button(int b, logic level, ms_time_t now,
                                  ev_code_t short_code, ev_code_t long_code);
      ms_time_t since_edge;
      ms_time_t since_press;
      if (level != raw_lvl[b]) begin
        raw_lvl[b] = level;
        edge_at[b] = now;
      end
      since_edge = now - edge_at[b];
      if (since_edge >= ms_time_t'(debounce_ms) && stable_lvl[b] != raw_lvl[b]) begin
        stable_lvl[b] = raw_lvl[b];
        if (stable_lvl[b]) begin
          press_at[b]  = now;
          long_done[b] = 1'b0;
        end else if (!long_done[b]) begin
          push_event(short_code);
        end
      end
      since_press = now - press_at[b];
      if (stable_lvl[b] && !long_done[b] && since_press >= ms_time_t'(long_ms)) begin
        long_done[b] = 1'b1;
        push_event(long_code);
      end
    endfunction

    function void note_poll(ms_time_t now, logic first, logic second, logic pop);
      poll_result_t res;
      debounce_button(0, first,  now, EV_FIRST_SHORT,  EV_FIRST_LONG);
      debounce_button(1, second, now, EV_SECOND_SHORT, EV_SECOND_LONG);
      res.code  = pop ? pop_event() : EV_NONE;
      res.level = QLVL_W'((tail + RING_DEPTH - head) % RING_DEPTH);
      pending_results.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(ev_code_t code, logic [QLVL_W-1:0] level);
      poll_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending (event %0d level %0d)",
                         code, level));
        return;
      end
      want = pending_results.pop_front();
      if (code !== want.code)
        report($sformatf("event_code %0d, want %0d", code, want.code));
      if (level !== want.level)
        report($sformatf("queue_level %0d, want %0d", level, want.level));
    endtask

    task flush_leftovers();
      while (pending_results.size() != 0) begin
        report($sformatf("result never came (event %0d level %0d)",
                         pending_results[0].code, pending_results[0].level));
        void'(pending_results.pop_front());
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [TIME_W-1:0]    in_now_ms;
  logic                 in_first_pressed_raw;
  logic                 in_second_pressed_raw;
  logic                 in_pop_request;
  logic                 out_valid;
  logic                 out_ready;
  logic [EV_W-1:0]      out_event_code;
  logic [QLVL_W-1:0]    out_queue_level;

  dual_button_press_classifier i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_now_ms             (in_now_ms),
    .in_first_pressed_raw  (in_first_pressed_raw),
    .in_second_pressed_raw (in_second_pressed_raw),
    .in_pop_request        (in_pop_request),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_event_code        (out_event_code),
    .out_queue_level       (out_queue_level)
  );

  press_classifier_sb sb;

  // flow control knobs, percent of cycles that idle or stall
  int in_idle_pct;
  int out_stall_pct;

  // random poll generator: a wrapping clock and the level each button holds
  ms_time_t    t_gen;
  logic        gen_lvl   [NUM_BTN];
  int unsigned hold_left [NUM_BTN];
  cfg_val_t    cur_debounce;
  cfg_val_t    cur_long;

  int unsigned cycle_count = 0;

  always #(CLK_HALF) clk = ~clk;

  // watchdog, a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: sample the transaction before this edge's updates land,
  // then pick a fresh ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_event_code, out_queue_level);
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // one poll transaction; valid stays up with a fixed payload until taken
  task automatic send_poll(input ms_time_t now, input logic first,
                           input logic second, input logic pop);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_now_ms             <= now;
    in_first_pressed_raw  <= first;
    in_second_pressed_raw <= second;
    in_pop_request        <= pop;
    do @(posedge clk); while (!in_ready);
    sb.note_poll(now, first, second, pop);
  endtask

  // every poll gives exactly one result, so an empty pending list means idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // both registers, then both unused indexes with junk that must not stick
  task automatic write_settings(input cfg_val_t deb, input cfg_val_t lp);
    logic [CFG_IDX_W-1:0] idx [4];
    cfg_val_t             val [4];
    idx = '{CFG_DEBOUNCE, CFG_LONG_PRESS, CFG_SPARE_LO, CFG_SPARE_HI};
    val = '{deb, lp, cfg_val_t'($urandom), cfg_val_t'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      sb.set_register(idx[k], val[k]);
    end
    cfg_wr_en    <= 1'b0;
    cur_debounce = deb;
    cur_long     = lp;
  endtask

  // hold lengths around the current thresholds: bounces, short and long presses
  function automatic int unsigned pick_hold();
    if ($urandom_range(0, 1))
      return $urandom_range(0, cur_debounce + cur_long + 4);
    return $urandom_range(0, cur_debounce + 2 * cur_long + 8);
  endfunction

  // mostly press sequences on a steadily advancing clock, a few noise polls
  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    int unsigned step;
    int unsigned step_max;
    int unsigned pop_pct;
    logic        lvl_now [NUM_BTN];
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    step_max      = (cur_debounce + cur_long) / 6 + 3;
    // start just below the wrap point so time differences cross zero
    t_gen   = 32'hFFFF_FFFF - $urandom_range(0, 100000);
    pop_pct = 30;
    for (int i = 0; i < n; i++) begin
      // pop rate changes in stretches so the ring both fills and drains
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       pop_pct = 0;
          1:       pop_pct = 15;
          2:       pop_pct = 50;
          default: pop_pct = 90;
        endcase
      end
      if ($urandom_range(0, 99) < 4) begin
        // noise: timestamp jump and random levels
        send_poll($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        step  = $urandom_range(0, step_max);
        t_gen = t_gen + step;
        for (int b = 0; b < NUM_BTN; b++) begin
          if (step >= hold_left[b]) begin
            gen_lvl[b]   = ~gen_lvl[b];
            hold_left[b] = pick_hold();
          end else begin
            hold_left[b] -= step;
          end
          // single-poll glitch against the held level
          lvl_now[b] = ($urandom_range(0, 99) < 3) ? ~gen_lvl[b] : gen_lvl[b];
        end
        send_poll(t_gen, lvl_now[0], lvl_now[1], $urandom_range(0, 99) < pop_pct);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n                 <= 1'b0;
    cfg_wr_en             <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    in_valid              <= 1'b0;
    in_now_ms             <= '0;
    in_first_pressed_raw  <= 1'b0;
    in_second_pressed_raw <= 1'b0;
    in_pop_request        <= 1'b0;
    out_ready             <= 1'b0;
    in_idle_pct   = 7;
    out_stall_pct = 50;
    cur_debounce  = DEBOUNCE_RESET;
    cur_long      = LONG_PRESS_RESET;
    for (int b = 0; b < NUM_BTN; b++) begin
      gen_lvl[b]   = 1'b0;
      hold_left[b] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds: 50 ms debounce, 1000 ms long press
    send_poll(32'h0000_0000, 1'b0, 1'b0, 1'b1);  // pop on an empty ring
    send_poll(32'h0000_000A, 1'b1, 1'b0, 1'b0);  // first button raw edge
    send_poll(32'h0000_003C, 1'b1, 1'b0, 1'b0);  // held 50 ms, now stable
    send_poll(32'h0000_0064, 1'b0, 1'b1, 1'b0);
    send_poll(32'h0000_0096, 1'b0, 1'b1, 1'b1);  // first short, popped at once
    send_poll(32'h0000_047E, 1'b0, 1'b1, 1'b1);  // second held to long press
    send_poll(32'h0000_04B0, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0000_04E2, 1'b0, 1'b0, 1'b1);  // release after long, no short
    send_poll(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0);  // both edges just before wrap
    send_poll(32'h0000_0022, 1'b1, 1'b1, 1'b0);  // debounce across the wrap
    send_poll(32'h0000_0030, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0000_0062, 1'b0, 1'b0, 1'b1);  // two shorts, one popped
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);  // top timestamp, pop the other

    // zero thresholds: long event on the press itself, none on release
    wait_idle();
    write_settings(cfg_val_t'(0), cfg_val_t'(0));
    send_poll(32'h0000_0100, 1'b1, 1'b1, 1'b0);
    send_poll(32'h0000_0101, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0000_0102, 1'b1, 1'b1, 1'b0);
    send_poll(32'h0000_0103, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0000_0104, 1'b1, 1'b1, 1'b0);
    send_poll(32'h0000_0105, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0000_0106, 1'b1, 1'b1, 1'b0);  // ring full, one event lost
    send_poll(32'h0000_0107, 1'b0, 1'b0, 1'b1);
    send_poll(32'h0000_0108, 1'b0, 1'b0, 1'b1);
    send_poll(32'h0000_0109, 1'b0, 1'b0, 1'b1);
    send_poll(32'h0000_010A, 1'b0, 1'b0, 1'b1);

    // random phases: receiver stalls heavily, then sender idles heavily,
    // then full rate with the zero-threshold corners
    wait_idle();
    write_settings(cfg_val_t'($urandom_range(1, 200)), cfg_val_t'($urandom_range(100, 3000)));
    run_random(545, 7, 50);

    wait_idle();
    write_settings(cfg_val_t'(16'hFFFF), cfg_val_t'(16'hFFFF));
    run_random(545, 50, 7);

    wait_idle();
    write_settings(cfg_val_t'($urandom_range(1, 80)), cfg_val_t'(0));
    run_random(280, 0, 0);

    wait_idle();
    write_settings(cfg_val_t'(0), cfg_val_t'($urandom_range(1, 1500)));
    run_random(280, 0, 0);

    wait_idle();
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dbpc_pkg.sv
src/dbpc_front.sv
src/dbpc_fifo.sv
src/dbpc_back.sv
src/dual_button_press_classifier.sv
verif/dual_button_press_classifier_tb.sv
